// ===== hw/rtl/residue_mask_sieve_filter_core_defines.svh =====
// ----------------------------------------------------------------------------
// Residue mask sieve filter - assertion macros
// Shared property templates for the filter's RTL modules.
// ----------------------------------------------------------------------------
`ifndef RESIDUE_MASK_SIEVE_FILTER_CORE_DEFINES_SVH
`define RESIDUE_MASK_SIEVE_FILTER_CORE_DEFINES_SVH

// same-cycle implication
`define RMSF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RMSF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/rmsf_pkg.sv =====
// ----------------------------------------------------------------------------
// rmsf_pkg
// Types, codes and arithmetic helpers of the residue mask sieve filter.
// ----------------------------------------------------------------------------
package rmsf_pkg;

  localparam int NUM_SLOTS = 64;
  localparam int SLOT_W    = 6;
  localparam int RES_W     = 8;
  localparam int VAL_W     = 32;
  localparam int ACT_W     = 7;

  typedef enum logic [1:0] {
    CMD_PRIME = 2'd0,
    CMD_BIT   = 2'd1,
    CMD_TEST  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    VERD_PASS    = 2'd0,
    VERD_NOTPRIM = 2'd1,
    VERD_MASK    = 2'd2
  } verd_t;

  typedef enum logic [2:0] {
    ST_CLR,
    ST_IDLE,
    ST_RED,
    ST_SCAN,
    ST_RD,
    ST_CHN,
    ST_FIN
  } st_t;

  typedef struct packed {
    logic              clr;
    logic [8:0]        clr_addr;
    logic              pw;
    logic              bw;
    logic [SLOT_W-1:0] slot;
    logic [RES_W-1:0]  prime;
    logic              wbranch;
    logic [RES_W-1:0]  residue;
    logic              pass_bit;
    logic              start;
    logic              red;
    logic              nbit;
    logic              dbit;
    logic              scan;
    logic [RES_W-1:0]  cnt;
    logic              rd;
    logic              branch;
  } cell_ctl_t;

  typedef struct packed {
    logic              rej;
    logic [SLOT_W-1:0] slot;
  } tok_t;

  function automatic logic [RES_W-1:0] mod_dbl(input logic [RES_W-1:0] r,
                                               input logic b,
                                               input logic [RES_W-1:0] p);
    logic [RES_W:0] t;
    t = {r, b};
    if (t >= {1'b0, p}) t = t - {1'b0, p};
    return t[RES_W-1:0];
  endfunction

  function automatic logic [RES_W-1:0] mod_add(input logic [RES_W-1:0] a,
                                               input logic [RES_W-1:0] b,
                                               input logic [RES_W-1:0] p);
    logic [RES_W:0] t;
    t = {1'b0, a} + {1'b0, b};
    if (t >= {1'b0, p}) t = t - {1'b0, p};
    return t[RES_W-1:0];
  endfunction

endpackage

// ===== hw/rtl/rmsf_if.sv =====
// ----------------------------------------------------------------------------
// rmsf_if
// Valid/ready channels of the residue mask sieve filter.
// ----------------------------------------------------------------------------
interface rmsf_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [5:0]  slot;
  logic [7:0]  prime;
  logic        branch;
  logic [7:0]  residue;
  logic        pass_bit;
  logic [31:0] numerator;
  logic [31:0] denominator;
  modport source (output valid, command, slot, prime, branch, residue, pass_bit,
                  numerator, denominator, input ready);
  modport sink (input valid, command, slot, prime, branch, residue, pass_bit,
                numerator, denominator, output ready);
endinterface

interface rmsf_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] verdict;
  logic [5:0] rejecting_slot;
  modport source (output valid, verdict, rejecting_slot, input ready);
  modport sink (input valid, verdict, rejecting_slot, output ready);
endinterface

// ===== hw/rtl/rmsf_gcd.sv =====
// ----------------------------------------------------------------------------
// rmsf_gcd
// Binary gcd unit, one step per cycle; flags whether gcd(a, b) is one.
// ----------------------------------------------------------------------------
module rmsf_gcd (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [rmsf_pkg::VAL_W-1:0]  a,
  input  logic [rmsf_pkg::VAL_W-1:0]  b,
  output logic                        done,
  output logic                        is_one
);

  logic [rmsf_pkg::VAL_W-1:0] a_r, b_r;
  logic busy_r, done_r, one_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      one_r  <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
    end else if (busy_r) begin
      if (a_r == '0) begin
        one_r  <= (b_r == rmsf_pkg::VAL_W'(1));
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end else if (b_r == '0) begin
        one_r  <= (a_r == rmsf_pkg::VAL_W'(1));
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end else if (!a_r[0] && !b_r[0]) begin
        one_r  <= 1'b0;
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      b_r <= b;
    end else if (busy_r && a_r != '0 && b_r != '0) begin
      if (!a_r[0])          a_r <= a_r >> 1;
      else if (!b_r[0])     b_r <= b_r >> 1;
      else if (a_r >= b_r)  a_r <= a_r - b_r;
      else                  b_r <= b_r - a_r;
    end
  end

  assign done   = done_r;
  assign is_one = one_r;

endmodule

// ===== hw/rtl/rmsf_cell.sv =====
// ----------------------------------------------------------------------------
// rmsf_cell
// One mask slot: prime, two residue bitmaps, residue search and reject token.
// ----------------------------------------------------------------------------
module rmsf_cell (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [rmsf_pkg::SLOT_W-1:0]  cell_id,
  input  logic                         active,
  input  rmsf_pkg::cell_ctl_t          ctl,
  input  rmsf_pkg::tok_t               tok_in,
  output rmsf_pkg::tok_t               tok_out
);

  logic [rmsf_pkg::RES_W-1:0] prime_r, nm_r, dm_r, acc_r, uf_r;
  logic found_r, zhit_r, bit_r;
  logic mem [0:511];
  logic sel, reject;
  rmsf_pkg::tok_t tok_r;

  assign sel = (ctl.slot == cell_id);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prime_r <= '0;
    end else if (ctl.pw && sel) begin
      prime_r <= ctl.prime;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      mem[ctl.clr_addr] <= 1'b0;
    end else if (ctl.bw && sel) begin
      mem[{ctl.wbranch, ctl.residue}] <= ctl.pass_bit;
    end
    if (ctl.rd) begin
      bit_r <= mem[{ctl.branch, uf_r}];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      nm_r    <= '0;
      dm_r    <= '0;
      acc_r   <= '0;
      uf_r    <= '0;
      found_r <= 1'b0;
      zhit_r  <= 1'b0;
    end else if (ctl.red) begin
      nm_r <= rmsf_pkg::mod_dbl(nm_r, ctl.nbit, prime_r);
      dm_r <= rmsf_pkg::mod_dbl(dm_r, ctl.dbit, prime_r);
    end else if (ctl.scan && ctl.cnt < prime_r) begin
      if (acc_r == nm_r && !found_r) begin
        found_r <= 1'b1;
        uf_r    <= ctl.cnt;
      end
      if (ctl.cnt != '0 && acc_r == '0) zhit_r <= 1'b1;
      acc_r <= rmsf_pkg::mod_add(acc_r, dm_r, prime_r);
    end
  end

  assign reject = active && (prime_r > rmsf_pkg::RES_W'(1)) && (dm_r != '0) &&
                  !zhit_r && !bit_r;

  always_ff @(posedge clk) begin
    if (tok_in.rej) begin
      tok_r <= tok_in;
    end else begin
      tok_r.rej  <= reject;
      tok_r.slot <= reject ? cell_id : '0;
    end
  end

  assign tok_out = tok_r;

endmodule

// ===== hw/rtl/residue_mask_sieve_filter_core.sv =====
// ----------------------------------------------------------------------------
// residue_mask_sieve_filter_core
// Tests fractions n/d against 64 slot residue masks in a chain of cells.
// ----------------------------------------------------------------------------
//  channel | dir | contents
//  in_bus  | in  | command, slot, prime, branch, residue, pass_bit, n, d
//  out_bus | out | verdict, rejecting_slot (one beat per test command)
//  cfg     | in  | cfg_we, cfg_wdata = active_slots
//
//  Set-prime, write-bit and unused commands leave the core in its idle state.
//  A test runs through 32 residue reduction steps, a 256 step residue search
//  in every cell, one bitmap read and 65 steps down the reject chain.
//  After reset, all 512 bitmap addresses are cleared; in_bus is not ready then.
//  A result waiting on out_bus does not block new input beats; a test stalls
//  at its end only while the previous result is still held.
// ----------------------------------------------------------------------------
`include "residue_mask_sieve_filter_core_defines.svh"

module residue_mask_sieve_filter_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [6:0]        cfg_wdata,
  rmsf_in_if.sink           in_bus,
  rmsf_out_if.source        out_bus
);

  rmsf_pkg::st_t st_r, st_nxt;
  logic [8:0] cnt_r, cnt_nxt;
  logic [rmsf_pkg::ACT_W-1:0] act_r;
  logic [rmsf_pkg::VAL_W-1:0] n_r, d_r;
  logic br_r;
  logic in_fire, start, gcd_done, gcd_one, out_load;
  logic out_valid_r;
  logic [1:0] verd_r;
  logic [5:0] rslot_r;
  rmsf_pkg::cell_ctl_t ctl;
  rmsf_pkg::tok_t tok [0:rmsf_pkg::NUM_SLOTS];

  assign in_fire = in_bus.valid && in_bus.ready;
  assign start   = in_fire && (in_bus.command == rmsf_pkg::CMD_TEST);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= '0;
    end else if (cfg_we) begin
      act_r <= cfg_wdata;
    end
  end

  always_comb begin
    st_nxt  = st_r;
    cnt_nxt = cnt_r + 9'd1;
    case (st_r)
      rmsf_pkg::ST_CLR: begin
        if (cnt_r == 9'd511) begin
          st_nxt  = rmsf_pkg::ST_IDLE;
          cnt_nxt = '0;
        end
      end
      rmsf_pkg::ST_IDLE: begin
        cnt_nxt = '0;
        if (start) st_nxt = rmsf_pkg::ST_RED;
      end
      rmsf_pkg::ST_RED: begin
        if (cnt_r == 9'd31) begin
          st_nxt  = rmsf_pkg::ST_SCAN;
          cnt_nxt = '0;
        end
      end
      rmsf_pkg::ST_SCAN: begin
        if (cnt_r == 9'd255) begin
          st_nxt  = rmsf_pkg::ST_RD;
          cnt_nxt = '0;
        end
      end
      rmsf_pkg::ST_RD: begin
        st_nxt  = rmsf_pkg::ST_CHN;
        cnt_nxt = '0;
      end
      rmsf_pkg::ST_CHN: begin
        if (cnt_r == 9'd64) begin
          st_nxt  = rmsf_pkg::ST_FIN;
          cnt_nxt = '0;
        end
      end
      rmsf_pkg::ST_FIN: begin
        cnt_nxt = '0;
        if (out_load) st_nxt = rmsf_pkg::ST_IDLE;
      end
      default: begin
        st_nxt  = rmsf_pkg::ST_IDLE;
        cnt_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= rmsf_pkg::ST_CLR;
      cnt_r <= '0;
    end else begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_comb begin
    in_bus.ready = (st_r == rmsf_pkg::ST_IDLE);
    out_load     = (st_r == rmsf_pkg::ST_FIN) && gcd_done &&
                   (!out_valid_r || out_bus.ready);
    ctl.clr      = (st_r == rmsf_pkg::ST_CLR);
    ctl.clr_addr = cnt_r;
    ctl.pw       = in_fire && (in_bus.command == rmsf_pkg::CMD_PRIME);
    ctl.bw       = in_fire && (in_bus.command == rmsf_pkg::CMD_BIT);
    ctl.slot     = in_bus.slot;
    ctl.prime    = in_bus.prime;
    ctl.wbranch  = in_bus.branch;
    ctl.residue  = in_bus.residue;
    ctl.pass_bit = in_bus.pass_bit;
    ctl.start    = start;
    ctl.red      = (st_r == rmsf_pkg::ST_RED);
    ctl.nbit     = n_r[rmsf_pkg::VAL_W-1];
    ctl.dbit     = d_r[rmsf_pkg::VAL_W-1];
    ctl.scan     = (st_r == rmsf_pkg::ST_SCAN);
    ctl.cnt      = cnt_r[7:0];
    ctl.rd       = (st_r == rmsf_pkg::ST_RD);
    ctl.branch   = br_r;
  end

  // hold the candidate, shift out MSB first during reduction
  always_ff @(posedge clk) begin
    if (start) begin
      n_r  <= in_bus.numerator;
      d_r  <= in_bus.denominator;
      br_r <= in_bus.branch;
    end else if (st_r == rmsf_pkg::ST_RED) begin
      n_r <= n_r << 1;
      d_r <= d_r << 1;
    end
  end

  rmsf_gcd u_gcd (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .a      (in_bus.numerator),
    .b      (in_bus.denominator),
    .done   (gcd_done),
    .is_one (gcd_one)
  );

  assign tok[0] = '0;

  for (genvar k = 0; k < rmsf_pkg::NUM_SLOTS; k++) begin : g_cell
    rmsf_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .cell_id (rmsf_pkg::SLOT_W'(k)),
      .active  (act_r > rmsf_pkg::ACT_W'(k)),
      .ctl     (ctl),
      .tok_in  (tok[k]),
      .tok_out (tok[k+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (!gcd_one) begin
        verd_r  <= rmsf_pkg::VERD_NOTPRIM;
        rslot_r <= '0;
      end else if (tok[rmsf_pkg::NUM_SLOTS].rej) begin
        verd_r  <= rmsf_pkg::VERD_MASK;
        rslot_r <= tok[rmsf_pkg::NUM_SLOTS].slot;
      end else begin
        verd_r  <= rmsf_pkg::VERD_PASS;
        rslot_r <= '0;
      end
    end
  end

  assign out_bus.valid          = out_valid_r;
  assign out_bus.verdict        = verd_r;
  assign out_bus.rejecting_slot = rslot_r;

  `RMSF_ASSERT_NOW(a_slot_zero,
    out_bus.valid && out_bus.verdict != rmsf_pkg::VERD_MASK,
    out_bus.rejecting_slot == '0, "slot set without mask reject")
  `RMSF_ASSERT_NOW(a_fin_gcd, out_load,
    gcd_done && st_r == rmsf_pkg::ST_FIN, "result loaded before gcd done")
  `RMSF_ASSERT_NEXT(a_test_start, start,
    st_r == rmsf_pkg::ST_RED && !in_bus.ready, "test beat did not start reduction")

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Residue mask sieve filter testbench
// Loads slot primes and residue bitmaps, tests fractions under several
// active-slot settings and checks every verdict against a local predictor,
// with random idling on both channels under all but the last setting.
// ----------------------------------------------------------------------------
module tb;

  typedef struct {
    rmsf_pkg::cmd_t command;
    logic [5:0]     slot;
    logic [7:0]     prime;
    logic           branch;
    logic [7:0]     residue;
    logic           pass_bit;
    logic [31:0]    numerator;
    logic [31:0]    denominator;
  } sieve_item_t;

  typedef struct {
    rmsf_pkg::verd_t verdict;
    logic [5:0]      rej_slot;
  } verdict_t;

  class sieve_scoreboard;
    logic [7:0] primes [rmsf_pkg::NUM_SLOTS];
    bit         bitmap [rmsf_pkg::NUM_SLOTS][2][256];
    int         active;
    verdict_t   pending [$];
    int         mismatches;

    function new();
      foreach (primes[i]) primes[i] = '0;
      foreach (bitmap[i, j, k]) bitmap[i][j][k] = 1'b0;
      active = 0;
      mismatches = 0;
    endfunction

    function longint unsigned gcd(longint unsigned x, longint unsigned y);
      longint unsigned r;
      while (y != 0) begin
        r = x % y;
        x = y;
        y = r;
      end
      return x;
    endfunction

    function int inv_mod(int a, int m);
      int t0, t1, r0, r1, q, z;
      t0 = 0; t1 = 1; r0 = m; r1 = a;
      while (r1 != 0) begin
        q = r0 / r1;
        z = t0 - q * t1; t0 = t1; t1 = z;
        z = r0 - q * r1; r0 = r1; r1 = z;
      end
      if (r0 != 1) return -1;
      t0 = t0 % m;
      if (t0 < 0) t0 += m;
      return t0;
    endfunction

    function void note(sieve_item_t it);
      verdict_t v;
      int lim, p, dm, inv, u;
      case (it.command)
        rmsf_pkg::CMD_PRIME: primes[it.slot] = it.prime;
        rmsf_pkg::CMD_BIT: bitmap[it.slot][it.branch][it.residue] = it.pass_bit;
        rmsf_pkg::CMD_TEST: begin
          v.verdict = rmsf_pkg::VERD_PASS;
          v.rej_slot = '0;
          if (gcd(64'(it.numerator), 64'(it.denominator)) != 1) begin
            v.verdict = rmsf_pkg::VERD_NOTPRIM;
          end else begin
            lim = (active > rmsf_pkg::NUM_SLOTS) ? rmsf_pkg::NUM_SLOTS : active;
            for (int s = 0; s < lim; s++) begin
              p = int'(primes[s]);
              if (p < 2) continue;
              dm = int'(it.denominator % p);
              if (dm == 0) continue;
              inv = inv_mod(dm, p);
              if (inv < 0) continue;
              u = int'(((it.numerator % p) * inv) % p);
              if (!bitmap[s][it.branch][u]) begin
                v.verdict = rmsf_pkg::VERD_MASK;
                v.rej_slot = 6'(s);
                break;
              end
            end
          end
          pending.push_back(v);
        end
        default: ;
      endcase
    endfunction

    function void check(logic [1:0] verdict, logic [5:0] rej_slot);
      verdict_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected beat: verdict %0d slot %0d", verdict, rej_slot);
        return;
      end
      e = pending.pop_front();
      if (verdict !== e.verdict || rej_slot !== e.rej_slot) begin
        mismatches++;
        if (mismatches <= 10)
          $display("verdict exp %0d/%0d got %0d/%0d", e.verdict, e.rej_slot,
                   verdict, rej_slot);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [6:0] cfg_wdata = '0;
  bit quiet = 1'b0;
  int out_hold = 0;
  sieve_scoreboard sb = new();

  rmsf_in_if in_bus();
  rmsf_out_if out_bus();

  residue_mask_sieve_filter_core uut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_bus(in_bus.sink), .out_bus(out_bus.source)
  );

  always #6 clk = ~clk;

  // result side: random stall bursts
  always @(posedge clk) begin
    if (quiet || !rst_n) begin
      out_bus.ready <= rst_n;
    end else if (out_hold > 0) begin
      out_hold <= out_hold - 1;
      out_bus.ready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      out_hold <= int'($urandom_range(0, 5));
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= 1'b1;
    end
  end

  always @(negedge clk)
    if (rst_n && out_bus.valid && out_bus.ready)
      sb.check(out_bus.verdict, out_bus.rejecting_slot);

  task automatic send(sieve_item_t it);
    bit r;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.command <= it.command;
    in_bus.slot <= it.slot;
    in_bus.prime <= it.prime;
    in_bus.branch <= it.branch;
    in_bus.residue <= it.residue;
    in_bus.pass_bit <= it.pass_bit;
    in_bus.numerator <= it.numerator;
    in_bus.denominator <= it.denominator;
    do begin
      @(negedge clk) r = in_bus.ready;
      @(posedge clk);
    end while (!r);
    sb.note(it);
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_active(logic [6:0] v);
    in_bus.valid <= 1'b0;
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.active = int'(v);
  endtask

  function automatic sieve_item_t mk(rmsf_pkg::cmd_t c, int s, int pr, int br, int res,
                                     int pb, logic [31:0] n, logic [31:0] d);
    sieve_item_t it;
    it.command = c; it.slot = 6'(s); it.prime = 8'(pr); it.branch = 1'(br);
    it.residue = 8'(res); it.pass_bit = 1'(pb); it.numerator = n; it.denominator = d;
    return it;
  endfunction

  function automatic sieve_item_t rand_item();
    int small_primes [6] = '{2, 3, 5, 7, 11, 13};
    int k, s, pr;
    logic [31:0] d;
    k = $urandom_range(0, 99);
    s = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 7);
    if (k < 12) begin
      pr = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                       : small_primes[$urandom_range(0, 5)];
      return mk(rmsf_pkg::CMD_PRIME, s, pr, 0, 0, 0, $urandom, $urandom);
    end else if (k < 55) begin
      pr = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 12);
      return mk(rmsf_pkg::CMD_BIT, s, $urandom, $urandom_range(0, 1), pr,
                $urandom_range(0, 9) != 0, $urandom, $urandom);
    end else if (k < 96) begin
      d = $urandom;
      if ($urandom_range(0, 3) != 0) d[0] = 1'b1;
      if (d == 0) d = 1;
      return mk(rmsf_pkg::CMD_TEST, $urandom, $urandom, $urandom_range(0, 1), $urandom,
                $urandom_range(0, 1), $urandom, d);
    end
    return mk(rmsf_pkg::CMD_NONE, $urandom, $urandom, $urandom_range(0, 1), $urandom,
              $urandom_range(0, 1), $urandom, $urandom);
  endfunction

  initial begin
    logic [6:0] settings [5];
    settings = '{7'd64, 7'd1, 7'd127, 7'd0, 7'd8};
    in_bus.valid = 1'b0;
    in_bus.command = rmsf_pkg::CMD_NONE;
    in_bus.slot = '0;
    in_bus.prime = '0;
    in_bus.branch = 1'b0;
    in_bus.residue = '0;
    in_bus.pass_bit = 1'b0;
    in_bus.numerator = '0;
    in_bus.denominator = 32'd1;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_active(7'd64);
    send(mk(rmsf_pkg::CMD_PRIME, 0, 3, 0, 0, 0, 0, 1));
    send(mk(rmsf_pkg::CMD_PRIME, 1, 5, 0, 0, 0, 0, 1));
    send(mk(rmsf_pkg::CMD_PRIME, 2, 4, 0, 0, 0, 0, 1));
    send(mk(rmsf_pkg::CMD_PRIME, 3, 0, 0, 0, 0, 0, 1));
    send(mk(rmsf_pkg::CMD_PRIME, 63, 251, 0, 0, 0, 0, 1));
    send(mk(rmsf_pkg::CMD_PRIME, 4, 255, 0, 0, 0, 0, 1));
    send(mk(rmsf_pkg::CMD_BIT, 0, 0, 0, 0, 1, 0, 1));
    send(mk(rmsf_pkg::CMD_BIT, 0, 0, 0, 1, 1, 0, 1));
    send(mk(rmsf_pkg::CMD_BIT, 0, 0, 1, 2, 1, 0, 1));
    send(mk(rmsf_pkg::CMD_BIT, 1, 0, 0, 255, 1, 0, 1));
    send(mk(rmsf_pkg::CMD_BIT, 63, 0, 1, 250, 1, 0, 1));
    send(mk(rmsf_pkg::CMD_TEST, 0, 0, 0, 0, 0, 32'd0, 32'd1));
    send(mk(rmsf_pkg::CMD_TEST, 0, 0, 0, 0, 0, 32'd1, 32'd1));
    send(mk(rmsf_pkg::CMD_TEST, 0, 0, 0, 0, 0, 32'd6, 32'd4));
    send(mk(rmsf_pkg::CMD_TEST, 0, 0, 1, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFE));
    send(mk(rmsf_pkg::CMD_TEST, 0, 0, 0, 0, 0, 32'd1, 32'd3));
    send(mk(rmsf_pkg::CMD_TEST, 0, 0, 0, 0, 0, 32'd2, 32'd15));
    send(mk(rmsf_pkg::CMD_NONE, 63, 255, 1, 255, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send(mk(rmsf_pkg::CMD_PRIME, 0, 3, 0, 0, 0, 0, 1));
    send(mk(rmsf_pkg::CMD_TEST, 0, 0, 1, 0, 0, 32'd7, 32'd2));
    foreach (settings[p]) begin
      write_active(p == 0 ? 7'($urandom_range(0, 127)) : settings[p]);
      if (p == 4) quiet = 1'b1;
      repeat (375) send(rand_item());
    end
    in_bus.valid <= 1'b0;
    drain();
    if (sb.mismatches == 0)
      $display("residue_mask_sieve_filter_core: match");
    else
      $display("residue_mask_sieve_filter_core: mismatch");
    $finish;
  end

  initial begin
    #60ms;
    $display("residue_mask_sieve_filter_core: mismatch");
    $finish;
  end
endmodule
